FILE: hdl/assert_macros.svh
// Assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted
`define CHK_ON(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked property, also checked across reset
`define CHK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: hdl/rpe_pkg.sv
// Shared constants, types and helpers for the reprojection error pipeline
package rpe_pkg;

    localparam int COORD_W_DEF  = 32;
    localparam int POSE_ENTRIES = 12;
    localparam int POSE_ROT     = 9;
    localparam int QUOT_BITS    = 40;
    localparam int DIV_STEPS    = 4;
    localparam int DIV_STAGES   = 1 + QUOT_BITS / DIV_STEPS;
    localparam int XF_STAGES    = 4;
    localparam int OUT_STAGES   = 2;
    localparam int PIPE_STAGES  = XF_STAGES + DIV_STAGES + OUT_STAGES;
    localparam int ERR_W        = 46;

    localparam logic signed [ERR_W-1:0] S32_MAX = ERR_W'(64'sh7FFF_FFFF);
    localparam logic signed [ERR_W-1:0] S32_MIN = -S32_MAX - ERR_W'(1);

    typedef enum logic {
        ACT_LOAD  = 1'b0,
        ACT_POINT = 1'b1
    } t_action;

    typedef enum logic [2:0] {
        CFG_FOCAL_X  = 3'd0,
        CFG_FOCAL_Y  = 3'd1,
        CFG_CENTER_X = 3'd2,
        CFG_CENTER_Y = 3'd3,
        CFG_BASE_F   = 3'd4,
        CFG_STEREO   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic zpos;
        logic neg_x;
        logic neg_y;
    } t_flags;

    typedef struct packed {
        logic signed [31:0] u;
        logic signed [31:0] v;
        logic signed [31:0] r;
    } t_obs;

    typedef struct packed {
        logic [31:0] val;
        logic        clip;
    } t_sat;

    function automatic t_sat sat32(input logic signed [ERR_W-1:0] e);
        t_sat s;
        s.val  = e[31:0];
        s.clip = 1'b0;
        if (e > S32_MAX) begin
            s.val  = 32'h7FFF_FFFF;
            s.clip = 1'b1;
        end else if (e < S32_MIN) begin
            s.val  = 32'h8000_0000;
            s.clip = 1'b1;
        end
        return s;
    endfunction

endpackage

FILE: hdl/rpe_xform.sv
// Pose store, rigid transform and numerator products (four pipeline stages)
module rpe_xform #(
    parameter int CW = rpe_pkg::COORD_W_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [rpe_pkg::XF_STAGES-1:0]    i_en,
    input  logic                             i_pose_we,
    input  logic [3:0]                       i_pose_idx,
    input  logic signed [31:0]               i_pose_val,
    input  logic signed [31:0]               i_px,
    input  logic signed [31:0]               i_py,
    input  logic signed [31:0]               i_pz,
    input  logic [31:0]                      i_fx,
    input  logic [31:0]                      i_fy,
    input  logic [31:0]                      i_bf,
    output logic [CW+31:0]                   o_nx,
    output logic [CW+31:0]                   o_ny,
    output logic [CW+31:0]                   o_nb,
    output logic [CW-1:0]                    o_den,
    output rpe_pkg::t_flags                  o_flags
);
    import rpe_pkg::*;

    localparam int NW = CW + 32;
    localparam int HW = (CW + 1) / 2;
    localparam int PW = HW + 32;
    localparam logic signed [63:0] C_HI = (64'sd1 <<< (CW - 1)) - 64'sd1;
    localparam logic signed [63:0] C_LO = -C_HI - 64'sd1;

    logic signed [31:0] r_pose [POSE_ENTRIES];
    logic signed [31:0] pt [3];
    logic signed [63:0] r_prod [9];
    logic signed [31:0] r_t [3];
    logic signed [65:0] sum [3];
    logic signed [63:0] vsum [3];
    logic signed [CW-1:0] n_c [3];
    logic signed [CW-1:0] r_c [3];
    logic [CW-1:0] mag [2];
    logic [2*HW-1:0] magp [2];
    logic [31:0] fsel [2];
    logic [PW-1:0] n_pl [2];
    logic [PW-1:0] n_ph [2];
    logic [PW-1:0] r_pl [2];
    logic [PW-1:0] r_ph [2];
    logic [CW-1:0] n_den;
    logic [CW-1:0] r_den2;
    logic [CW-1:0] r_den3;
    t_flags n_fl;
    t_flags r_fl2;
    t_flags r_fl3;
    logic [NW-1:0] r_nx;
    logic [NW-1:0] r_ny;
    logic [NW-1:0] r_nb;

    assign pt[0] = i_px;
    assign pt[1] = i_py;
    assign pt[2] = i_pz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < POSE_ENTRIES; i++) r_pose[i] <= '0;
        end else if (i_pose_we && (i_pose_idx < 4'(POSE_ENTRIES))) begin
            r_pose[i_pose_idx] <= i_pose_val;
        end
    end

    // Products are exact: Q2.30 times Q16.16 in 64 bits
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int i = 0; i < 9; i++) r_prod[i] <= r_pose[i] * pt[i % 3];
            for (int r = 0; r < 3; r++) r_t[r] <= r_pose[POSE_ROT + r];
        end
    end

    // Floor the row sum once, add translation, clamp to coordinate width
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            sum[r]  = 66'(r_prod[3*r]) + 66'(r_prod[3*r+1]) + 66'(r_prod[3*r+2]);
            vsum[r] = 64'(sum[r] >>> 30) + 64'(r_t[r]);
            if (vsum[r] > C_HI) begin
                n_c[r] = CW'(C_HI);
            end else if (vsum[r] < C_LO) begin
                n_c[r] = CW'(C_LO);
            end else begin
                n_c[r] = CW'(vsum[r]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            for (int r = 0; r < 3; r++) r_c[r] <= n_c[r];
        end
    end

    // Magnitude times focal length, split into two half-width products
    assign fsel[0] = i_fx;
    assign fsel[1] = i_fy;

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            mag[k]  = r_c[k][CW-1] ? CW'(-r_c[k]) : CW'(r_c[k]);
            magp[k] = (2*HW)'(mag[k]);
            n_pl[k] = PW'(magp[k][HW-1:0]) * PW'(fsel[k]);
            n_ph[k] = PW'(magp[k][2*HW-1:HW]) * PW'(fsel[k]);
        end
        n_fl.neg_x = r_c[0][CW-1];
        n_fl.neg_y = r_c[1][CW-1];
        n_fl.zpos  = !r_c[2][CW-1] && (r_c[2] != '0);
        n_den      = n_fl.zpos ? CW'(r_c[2]) : CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_pl   <= n_pl;
            r_ph   <= n_ph;
            r_den2 <= n_den;
            r_fl2  <= n_fl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_nx   <= NW'(r_pl[0]) + (NW'(r_ph[0]) << HW);
            r_ny   <= NW'(r_pl[1]) + (NW'(r_ph[1]) << HW);
            r_nb   <= NW'({i_bf, 16'h0000});
            r_den3 <= r_den2;
            r_fl3  <= r_fl2;
        end
    end

    assign o_nx    = r_nx;
    assign o_ny    = r_ny;
    assign o_nb    = r_nb;
    assign o_den   = r_den3;
    assign o_flags = r_fl3;

endmodule

FILE: hdl/rpe_div.sv
// Pipelined restoring divider with a capped quotient, one lane
module rpe_div #(
    parameter int CW = rpe_pkg::COORD_W_DEF
) (
    input  logic                             i_clk,
    input  logic [rpe_pkg::DIV_STAGES-1:0]   i_en,
    input  logic [CW+31:0]                   i_num,
    input  logic [CW-1:0]                    i_den,
    output logic [rpe_pkg::QUOT_BITS:0]      o_quot
);
    import rpe_pkg::*;

    localparam int NW = CW + 32;
    localparam int HB = NW - QUOT_BITS;
    localparam int LS = DIV_STAGES - 1;

    logic [CW-1:0]        r_rem [DIV_STAGES];
    logic [CW-1:0]        r_den [DIV_STAGES];
    logic [QUOT_BITS-1:0] r_q   [DIV_STAGES];
    logic [QUOT_BITS-1:0] r_lo  [DIV_STAGES];
    logic                 r_big [DIV_STAGES];
    logic [HB-1:0]        num_hi;

    assign num_hi = i_num[NW-1:QUOT_BITS];

    // Quotient reaches the cap exactly when the upper part is not below the divisor
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_big[0] <= CW'(num_hi) >= i_den;
            r_rem[0] <= CW'(num_hi);
            r_lo[0]  <= i_num[QUOT_BITS-1:0];
            r_q[0]   <= '0;
            r_den[0] <= i_den;
        end
    end

    for (genvar s = 1; s < DIV_STAGES; s++) begin : g_stage
        logic [CW-1:0]        n_rem;
        logic [QUOT_BITS-1:0] n_q;
        logic [QUOT_BITS-1:0] n_lo;
        logic [CW-1:0]        sh;

        always_comb begin
            n_rem = r_rem[s-1];
            n_q   = r_q[s-1];
            n_lo  = r_lo[s-1];
            sh    = '0;
            for (int j = 0; j < DIV_STEPS; j++) begin
                sh   = {n_rem[CW-2:0], n_lo[QUOT_BITS-1]};
                n_lo = n_lo << 1;
                if (sh >= r_den[s-1]) begin
                    n_rem = sh - r_den[s-1];
                    n_q   = {n_q[QUOT_BITS-2:0], 1'b1};
                end else begin
                    n_rem = sh;
                    n_q   = {n_q[QUOT_BITS-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[s]) begin
                r_rem[s] <= n_rem;
                r_q[s]   <= n_q;
                r_lo[s]  <= n_lo;
                r_den[s] <= r_den[s-1];
                r_big[s] <= r_big[s-1];
            end
        end
    end

    assign o_quot = r_big[LS] ? {1'b1, {QUOT_BITS{1'b0}}} : {1'b0, r_q[LS]};

endmodule

FILE: hdl/rpe_out.sv
// Projection, error terms and saturation (two pipeline stages)
module rpe_out (
    input  logic                             i_clk,
    input  logic [rpe_pkg::OUT_STAGES-1:0]   i_en,
    input  logic [rpe_pkg::QUOT_BITS:0]      i_qx,
    input  logic [rpe_pkg::QUOT_BITS:0]      i_qy,
    input  logic [rpe_pkg::QUOT_BITS:0]      i_qb,
    input  rpe_pkg::t_flags                  i_flags,
    input  rpe_pkg::t_obs                    i_obs,
    input  logic [31:0]                      i_cx,
    input  logic [31:0]                      i_cy,
    input  logic                             i_stereo,
    output logic signed [31:0]               o_err_u,
    output logic signed [31:0]               o_err_v,
    output logic signed [31:0]               o_err_right_u,
    output logic                             o_depth_positive,
    output logic                             o_saturated
);
    import rpe_pkg::*;

    logic signed [ERR_W-1:0] qx;
    logic signed [ERR_W-1:0] qy;
    logic signed [ERR_W-1:0] n_pu;
    logic signed [ERR_W-1:0] n_pv;
    logic signed [ERR_W-1:0] n_pr;
    logic signed [ERR_W-1:0] r_pu;
    logic signed [ERR_W-1:0] r_pv;
    logic signed [ERR_W-1:0] r_pr;
    t_obs   r_obs;
    t_flags r_fl;
    t_sat   su;
    t_sat   sv;
    t_sat   sr;
    logic signed [31:0] r_eu;
    logic signed [31:0] r_ev;
    logic signed [31:0] r_er;
    logic r_dp;
    logic r_sat;

    always_comb begin
        qx   = ERR_W'(i_qx);
        qy   = ERR_W'(i_qy);
        n_pu = (i_flags.neg_x ? -qx : qx) + ERR_W'(i_cx);
        n_pv = (i_flags.neg_y ? -qy : qy) + ERR_W'(i_cy);
        n_pr = n_pu - ERR_W'(i_qb);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_pu  <= n_pu;
            r_pv  <= n_pv;
            r_pr  <= n_pr;
            r_obs <= i_obs;
            r_fl  <= i_flags;
        end
    end

    assign su = sat32(ERR_W'(r_obs.u) - r_pu);
    assign sv = sat32(ERR_W'(r_obs.v) - r_pv);
    assign sr = sat32(ERR_W'(r_obs.r) - r_pr);

    // Zero everything at or behind the camera; drop the right term in mono mode
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            if (!r_fl.zpos) begin
                r_eu  <= '0;
                r_ev  <= '0;
                r_er  <= '0;
                r_dp  <= 1'b0;
                r_sat <= 1'b0;
            end else begin
                r_eu  <= su.val;
                r_ev  <= sv.val;
                r_er  <= i_stereo ? sr.val : 32'h0;
                r_dp  <= 1'b1;
                r_sat <= su.clip | sv.clip | (i_stereo & sr.clip);
            end
        end
    end

    assign o_err_u          = r_eu;
    assign o_err_v          = r_ev;
    assign o_err_right_u    = r_er;
    assign o_depth_positive = r_dp;
    assign o_saturated      = r_sat;

endmodule

FILE: hdl/stereo_reprojection_error_top.sv
// Top level of the stereo reprojection error pipeline
//
//  channel  | handshake                    | beat
//  ---------+------------------------------+------------------------------------------
//  in       | i_in_valid / o_in_ready      | action, pose entry, world point, observation
//  out      | o_out_valid / i_out_ready    | three errors, depth flag, saturation flag
//  cfg      | i_cfg_valid / o_cfg_ready    | register index and 32-bit data
//
// One beat per cycle in while o_in_ready is high; a point passes through four transform
// stages, eleven divider stages (a setup stage, then four quotient bits per later stage)
// and two output stages. Load beats write the pose store as they are taken and produce
// no result. Synchronous active-low reset clears valid bits, configuration and the pose
// store. Each stage holds only when it is full and the stage after it holds, so bubbles
// close up and a stalled output does not stop the front while empty stages remain.
module stereo_reprojection_error_top #(
    parameter int COORD_WIDTH = rpe_pkg::COORD_W_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_action,
    input  logic [3:0]         i_pose_index,
    input  logic signed [31:0] i_pose_value,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    input  logic signed [31:0] i_obs_u,
    input  logic signed [31:0] i_obs_v,
    input  logic signed [31:0] i_obs_right_u,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_err_u,
    output logic signed [31:0] o_err_v,
    output logic signed [31:0] o_err_right_u,
    output logic               o_depth_positive,
    output logic               o_saturated,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import rpe_pkg::*;

    localparam int DIV0 = XF_STAGES;
    localparam int OUT0 = XF_STAGES + DIV_STAGES;
    localparam int NW   = COORD_WIDTH + 32;

    logic [PIPE_STAGES-1:0] r_vld;
    logic [PIPE_STAGES:0]   stg_en;
    logic                   in_acc;

    logic [31:0] r_fx;
    logic [31:0] r_fy;
    logic [31:0] r_cx;
    logic [31:0] r_cy;
    logic [31:0] r_bf;
    logic        r_stereo;

    t_obs   r_obs [OUT0];
    t_flags r_fl  [DIV0:OUT0-1];

    logic [NW-1:0]          nx;
    logic [NW-1:0]          ny;
    logic [NW-1:0]          nb;
    logic [COORD_WIDTH-1:0] den;
    t_flags                 xf_fl;
    logic [QUOT_BITS:0]     qx;
    logic [QUOT_BITS:0]     qy;
    logic [QUOT_BITS:0]     qb;

    // A stage advances when empty or when the stage after it advances
    always_comb begin
        stg_en[PIPE_STAGES] = i_out_ready;
        for (int k = PIPE_STAGES - 1; k >= 0; k--) begin
            stg_en[k] = !r_vld[k] || stg_en[k+1];
        end
    end

    assign o_in_ready  = stg_en[0];
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_vld[PIPE_STAGES-1];
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_en[0]) r_vld[0] <= in_acc && (i_action == ACT_POINT);
            for (int k = 1; k < PIPE_STAGES; k++) begin
                if (stg_en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fx     <= '0;
            r_fy     <= '0;
            r_cx     <= '0;
            r_cy     <= '0;
            r_bf     <= '0;
            r_stereo <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FOCAL_X:  r_fx     <= i_cfg_data;
                CFG_FOCAL_Y:  r_fy     <= i_cfg_data;
                CFG_CENTER_X: r_cx     <= i_cfg_data;
                CFG_CENTER_Y: r_cy     <= i_cfg_data;
                CFG_BASE_F:   r_bf     <= i_cfg_data;
                CFG_STEREO:   r_stereo <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Observations and sign flags ride alongside the arithmetic
    always_ff @(posedge i_clk) begin
        if (stg_en[0]) r_obs[0] <= '{u: i_obs_u, v: i_obs_v, r: i_obs_right_u};
        for (int k = 1; k < OUT0; k++) begin
            if (stg_en[k]) r_obs[k] <= r_obs[k-1];
        end
        if (stg_en[DIV0]) r_fl[DIV0] <= xf_fl;
        for (int k = DIV0 + 1; k < OUT0; k++) begin
            if (stg_en[k]) r_fl[k] <= r_fl[k-1];
        end
    end

    rpe_xform #(.CW(COORD_WIDTH)) u_xform (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (stg_en[XF_STAGES-1:0]),
        .i_pose_we  (in_acc && (i_action == ACT_LOAD)),
        .i_pose_idx (i_pose_index),
        .i_pose_val (i_pose_value),
        .i_px       (i_point_x),
        .i_py       (i_point_y),
        .i_pz       (i_point_z),
        .i_fx       (r_fx),
        .i_fy       (r_fy),
        .i_bf       (r_bf),
        .o_nx       (nx),
        .o_ny       (ny),
        .o_nb       (nb),
        .o_den      (den),
        .o_flags    (xf_fl)
    );

    rpe_div #(.CW(COORD_WIDTH)) u_div_x (
        .i_clk  (i_clk),
        .i_en   (stg_en[OUT0-1:DIV0]),
        .i_num  (nx),
        .i_den  (den),
        .o_quot (qx)
    );

    rpe_div #(.CW(COORD_WIDTH)) u_div_y (
        .i_clk  (i_clk),
        .i_en   (stg_en[OUT0-1:DIV0]),
        .i_num  (ny),
        .i_den  (den),
        .o_quot (qy)
    );

    rpe_div #(.CW(COORD_WIDTH)) u_div_b (
        .i_clk  (i_clk),
        .i_en   (stg_en[OUT0-1:DIV0]),
        .i_num  (nb),
        .i_den  (den),
        .o_quot (qb)
    );

    rpe_out u_out (
        .i_clk            (i_clk),
        .i_en             (stg_en[PIPE_STAGES-1:OUT0]),
        .i_qx             (qx),
        .i_qy             (qy),
        .i_qb             (qb),
        .i_flags          (r_fl[OUT0-1]),
        .i_obs            (r_obs[OUT0-1]),
        .i_cx             (r_cx),
        .i_cy             (r_cy),
        .i_stereo         (r_stereo),
        .o_err_u          (o_err_u),
        .o_err_v          (o_err_v),
        .o_err_right_u    (o_err_right_u),
        .o_depth_positive (o_depth_positive),
        .o_saturated      (o_saturated)
    );

endmodule

FILE: hdl/rpe_chk.sv
// Port-level checker for the reprojection error top level, with its bind
`include "assert_macros.svh"

module rpe_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] o_err_u,
    input logic signed [31:0] o_err_v,
    input logic signed [31:0] o_err_right_u,
    input logic               o_depth_positive,
    input logic               o_saturated
);

    `CHK_ON(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid, "result beat dropped")
    `CHK_ON(a_out_stable, o_out_valid && !i_out_ready |=> $stable(o_err_u) && $stable(o_err_v), "stalled result changed")
    `CHK_ON(a_behind_zero, o_out_valid && !o_depth_positive |-> o_err_u == 0 && o_err_v == 0 && o_err_right_u == 0 && !o_saturated, "non-zero error behind camera")
    `CHK_ALWAYS(a_rst_empty, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind stereo_reprojection_error_top rpe_chk u_rpe_chk (.*);

FILE: verif/testbench.sv
// Self-checking testbench for the stereo reprojection error pipeline
`timescale 1ns / 100ps

module testbench;
    import rpe_pkg::*;

    localparam int DRAIN_CYCLES = PIPE_STAGES + 4;
    localparam int STALL_LIMIT  = 4000;
    localparam longint unsigned QCAP = 64'd1 << QUOT_BITS;

    typedef struct {
        t_action            act;
        logic [3:0]         idx;
        logic signed [31:0] pval;
        logic signed [31:0] px, py, pz;
        logic signed [31:0] ou, ov, orr;
    } beat_t;

    typedef struct {
        logic signed [31:0] eu, ev, er;
        logic               dpos, sat;
    } err_t;

    // Predicts the error beat of each point and keeps the ones still owed
    class reproj_scoreboard;
        logic [31:0] pose[POSE_ENTRIES];
        logic [31:0] fx, fy, cx, cy, bf;
        logic        stereo;
        err_t        owed[$];
        int          fails;

        function new();
            foreach (pose[i]) pose[i] = '0;
            {fx, fy, cx, cy, bf} = '0;
            stereo = 1'b0;
            fails  = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [31:0] v);
            case (idx)
                CFG_FOCAL_X:  fx = v;
                CFG_FOCAL_Y:  fy = v;
                CFG_CENTER_X: cx = v;
                CFG_CENTER_Y: cy = v;
                CFG_BASE_F:   bf = v;
                CFG_STEREO:   stereo = v[0];
                default: ;
            endcase
        endfunction

        // floor(R row . P / 2^30) + t, clamped to 32 signed bits
        function longint cam_row(int r, logic signed [31:0] p[3]);
            logic signed [65:0] acc, a, b;
            acc = '0;
            for (int c = 0; c < 3; c++) begin
                a = 66'(signed'(pose[r*3+c]));
                b = 66'(p[c]);
                acc = acc + a * b;
            end
            acc = (acc >>> 30) + 66'(signed'(pose[POSE_ROT+r]));
            if (acc > 66'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
            if (acc < -66'sh8000_0000) return -64'sh8000_0000;
            return longint'(acc);
        endfunction

        function longint unsigned capped_quot(longint unsigned a, longint unsigned b,
                                              longint unsigned d);
            logic [127:0] num, q;
            num = 128'(a) * 128'(b);
            q   = num / 128'(d);
            return (q >= 128'(QCAP)) ? QCAP : longint'(q[63:0]);
        endfunction

        function longint scaled(longint num, logic [31:0] f, longint unsigned d);
            longint unsigned q;
            q = capped_quot(num < 0 ? -num : num, {32'b0, f}, d);
            return num < 0 ? -longint'(q) : longint'(q);
        endfunction

        function logic [31:0] clamp32(longint e, ref logic clip);
            if (e > 64'sh7FFF_FFFF) begin
                clip = 1'b1;
                return 32'h7FFF_FFFF;
            end
            if (e < -64'sh8000_0000) begin
                clip = 1'b1;
                return 32'h8000_0000;
            end
            return e[31:0];
        endfunction

        function void note_beat(beat_t b);
            logic signed [31:0] p[3];
            longint xc, yc, zc, pu, pv, pr;
            err_t e;
            logic clip;
            if (b.act == ACT_LOAD) begin
                if (b.idx < POSE_ENTRIES) pose[b.idx] = b.pval;
                return;
            end
            p[0] = b.px; p[1] = b.py; p[2] = b.pz;
            xc = cam_row(0, p);
            yc = cam_row(1, p);
            zc = cam_row(2, p);
            e = '{default: '0};
            clip = 1'b0;
            if (zc > 0) begin
                pu = scaled(xc, fx, zc) + longint'({32'b0, cx});
                pv = scaled(yc, fy, zc) + longint'({32'b0, cy});
                e.eu = clamp32(longint'(b.ou) - pu, clip);
                e.ev = clamp32(longint'(b.ov) - pv, clip);
                if (stereo) begin
                    pr = pu - longint'(capped_quot({32'b0, bf}, 64'd65536, zc));
                    e.er = clamp32(longint'(b.orr) - pr, clip);
                end
                e.dpos = 1'b1;
                e.sat  = clip;
            end
            owed.push_back(e);
        endfunction

        task report(string what);
            $display("MISMATCH at %0t: %s", $time, what);
            fails++;
        endtask

        task check(err_t got);
            err_t w;
            if (owed.size() == 0) begin
                report("error beat with nothing owed");
                return;
            end
            w = owed.pop_front();
            if (got.eu !== w.eu) report($sformatf("err_u %h, want %h", got.eu, w.eu));
            if (got.ev !== w.ev) report($sformatf("err_v %h, want %h", got.ev, w.ev));
            if (got.er !== w.er) report($sformatf("err_right_u %h, want %h", got.er, w.er));
            if (got.dpos !== w.dpos) report($sformatf("depth_positive %b, want %b",
                                                      got.dpos, w.dpos));
            if (got.sat !== w.sat) report($sformatf("saturated %b, want %b",
                                                    got.sat, w.sat));
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_action = 1'b0;
    logic [3:0]         i_pose_index = '0;
    logic signed [31:0] i_pose_value = '0;
    logic signed [31:0] i_point_x = '0, i_point_y = '0, i_point_z = '0;
    logic signed [31:0] i_obs_u = '0, i_obs_v = '0, i_obs_right_u = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [31:0] o_err_u, o_err_v, o_err_right_u;
    logic               o_depth_positive, o_saturated;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_data = '0;

    reproj_scoreboard sb = new();
    logic hold_off = 1'b0;
    int   burst_left = 0;
    int   idle_cycles = 0;
    int   rx_cycle = 0;

    stereo_reprojection_error_top DUT (.*);

    always #5 i_clk = ~i_clk;

    // Receiver: stall pattern rotates through four modes driven by rx_cycle; long hold-off on request
    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready)
            sb.check('{o_err_u, o_err_v, o_err_right_u, o_depth_positive, o_saturated});
        rx_cycle <= rx_cycle + 1;
        if (hold_off || !i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            case ((rx_cycle >> 6) % 4)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= ($urandom_range(3) != 0);
                2: i_out_ready <= rx_cycle[0];
                default: i_out_ready <= ($urandom_range(3) == 0);
            endcase
        end
    end

    // Watchdog: nothing accepted anywhere for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("stereo_reprojection_error_top verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Hold the receiver off long enough for the pipeline to fill and stall its input
    initial begin
        repeat (600) @(posedge i_clk);
        while (!i_in_valid) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (200) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    task send(beat_t b);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(3) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid    <= 1'b1;
        i_action      <= b.act;
        i_pose_index  <= b.idx;
        i_pose_value  <= b.pval;
        i_point_x     <= b.px;
        i_point_y     <= b.py;
        i_point_z     <= b.pz;
        i_obs_u       <= b.ou;
        i_obs_v       <= b.ov;
        i_obs_right_u <= b.orr;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_beat(b);
    endtask

    // Leave valid high; the caller drops it after the last write
    task write_reg(t_cfg_idx idx, logic [31:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, v);
    endtask

    task settle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task apply_config(logic [31:0] fx, fy, cx, cy, bf, logic st);
        write_reg(CFG_FOCAL_X, fx);
        write_reg(CFG_FOCAL_Y, fy);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_BASE_F, bf);
        write_reg(CFG_STEREO, {31'b0, st});
        i_cfg_valid <= 1'b0;
    endtask

    function beat_t load_beat(logic [3:0] idx, logic [31:0] v);
        beat_t b;
        b = '{act: ACT_LOAD, idx: idx, pval: v, default: '0};
        b.px = $urandom; b.ou = $urandom;
        return b;
    endfunction

    function beat_t point_beat(logic [31:0] x, y, z, u, v, r);
        beat_t b;
        b = '{act: ACT_POINT, idx: 4'($urandom), pval: $urandom,
              px: x, py: y, pz: z, ou: u, ov: v, orr: r};
        return b;
    endfunction

    function logic [31:0] spread(int bits);
        return 32'($signed($urandom_range(0, (1 << bits) - 1)) - (1 << (bits - 1)));
    endfunction

    // Near-identity rotation, small x/y shift, positive depth offset
    task load_pose();
        for (int i = 0; i < POSE_ROT; i++)
            send(load_beat(4'(i), (i % 4 == 0) ? 32'h4000_0000 + spread(27) : spread(27)));
        send(load_beat(4'(POSE_ROT), spread(22)));
        send(load_beat(4'(POSE_ROT + 1), spread(22)));
        send(load_beat(4'(POSE_ROT + 2), 32'($urandom_range(1 << 18, 1 << 23))));
    endtask

    function beat_t random_beat();
        int pick;
        pick = $urandom_range(99);
        if (pick < 6)
            return load_beat(4'($urandom), $urandom);
        if (pick < 14)
            return point_beat($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        return point_beat(spread(21), spread(21), spread(21),
                          spread(27), spread(27), spread(27));
    endfunction

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        apply_config(32'd500 << 16, 32'd480 << 16, 32'd320 << 16, 32'd240 << 16,
                     32'd40 << 16, 1'b1);
        // zero pose puts every point at zero depth
        send(point_beat(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0));
        // out-of-range pose index is dropped
        send(load_beat(4'hF, 32'hFFFF_FFFF));
        send(load_beat(4'hC, 32'h4000_0000));
        send(point_beat(0, 0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
        load_pose();
        send(point_beat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
        send(point_beat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
        send(point_beat(32'h0001_0000, 32'hFFFF_0000, 32'hFF00_0000, 0, 0, 0));
        send(point_beat(0, 0, 32'h0000_0001, 0, 0, 0));
        send(load_beat(0, 32'h8000_0000));
        send(load_beat(8, 32'h7FFF_FFFF));
        send(point_beat(32'h0100_0000, 32'h0100_0000, 32'h0100_0000,
                        32'hFFFF_FFFF, 32'h0000_0001, 32'h1234_5678));

        for (int ph = 0; ph < 5; ph++) begin
            if (ph > 0) begin
                settle();
                case (ph)
                    1: apply_config(0, 0, 0, 0, 0, 1'b0);
                    2: apply_config('1, '1, '1, '1, '1, 1'b1);
                    3: apply_config($urandom, $urandom, $urandom, $urandom, $urandom,
                                    1'($urandom));
                    default: apply_config(32'd700 << 16, 32'd700 << 16, 32'd640 << 16,
                                          32'd360 << 16, 32'd120 << 16, 1'b0);
                endcase
            end
            load_pose();
            for (int n = 0; n < 110; n++) begin
                if ($urandom_range(39) == 0) load_pose();
                send(random_beat());
            end
        end

        settle();
        if (sb.fails == 0 && sb.owed.size() == 0)
            $display("stereo_reprojection_error_top verification clean");
        else
            $display("stereo_reprojection_error_top verification failed");
        $finish;
    end

endmodule
